FILE: hdl/rational_arithmetic_unit_core_assert.svh
// assertion macros for the rational arithmetic unit checker
// no dependencies
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define RAU_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rau check failed");
// next-cycle implication
`define RAU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rau check failed");
`endif

FILE: hdl/rau_pkg.sv
// shared constants, codes and command types for the rational arithmetic unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;
	localparam int WORD_BITS = 32;
	localparam int MAG_BITS = 64;

	localparam logic [2:0] FUNC_ADD = 3'd0;
	localparam logic [2:0] FUNC_SUB = 3'd1;
	localparam logic [2:0] FUNC_MUL = 3'd2;
	localparam logic [2:0] FUNC_DIV = 3'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_OVF = 2'd2;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL_AD_BD,
		OP_MUL_AN_BD,
		OP_MUL_BN_AD,
		OP_MUL_AN_BN,
		OP_SET_LCM,
		OP_SCALE,
		OP_ADD,
		OP_SET_MUL,
		OP_SET_DIV,
		OP_GCD_START,
		OP_GCD_STEP,
		OP_DIV_START,
		OP_DIV_STEP,
		OP_FINISH
	} op_t;

	typedef struct packed {
		op_t op;
		logic sel;
	} cmd_t;

	typedef struct packed {
		logic gcd_done;
		logic div_done;
		logic zero_err;
		logic is_cmp;
		logic is_addsub;
		logic is_mul;
	} stat_t;
endpackage
`default_nettype wire

FILE: hdl/rau_datapath.sv
// datapath: operand registers, shared multiplier, restoring divider, gcd by remainders
// depends on rau_pkg
`timescale 1ns / 1ps
`default_nettype none
module rau_datapath import rau_pkg::*; (
	input wire logic clk,
	input wire cmd_t cmd,
	input wire logic [2:0] func,
	input wire logic [WORD_BITS-1:0] a_num,
	input wire logic [WORD_BITS-1:0] a_den,
	input wire logic [WORD_BITS-1:0] b_num,
	input wire logic [WORD_BITS-1:0] b_den,
	output stat_t stat,
	output logic [WORD_BITS-1:0] res_num,
	output logic [WORD_BITS-2:0] res_den,
	output logic less,
	output logic greater,
	output logic [1:0] status
);
	localparam int CW = $clog2(MAG_BITS + 1);

	logic [2:0] func_q;
	logic [WORD_BITS-1:0] man_q, mad_q, mbn_q, mbd_q;
	logic sa_q, sb_q, sr_q;
	logic [MAG_BITS-1:0] p1_q, p2_q, den_q, num_q;
	logic [MAG_BITS-1:0] gx_q, gy_q;
	logic [MAG_BITS-1:0] dq_q, dr_q, dd_q;
	logic [CW-1:0] dcnt_q;
	logic dsel_q;
	logic zero_q;

	function automatic logic [WORD_BITS-1:0] mag(input logic [WORD_BITS-1:0] v);
		return v[WORD_BITS-1] ? (~v + 1'b1) : v;
	endfunction

	logic [WORD_BITS-1:0] ma, mb;
	logic [MAG_BITS-1:0] prod;
	always_comb begin
		unique case (cmd.op)
			OP_MUL_AD_BD: begin ma = mad_q; mb = mbd_q; end
			OP_MUL_AN_BD: begin ma = man_q; mb = mbd_q; end
			OP_MUL_BN_AD: begin ma = mbn_q; mb = mad_q; end
			OP_MUL_AN_BN: begin ma = man_q; mb = mbn_q; end
			default: begin ma = dq_q[WORD_BITS-1:0]; mb = cmd.sel ? mbd_q : mad_q; end
		endcase
		prod = MAG_BITS'(ma) * MAG_BITS'(mb);
	end

	logic [MAG_BITS:0] trial;
	logic [MAG_BITS-1:0] rsh;
	assign rsh = {dr_q[MAG_BITS-2:0], dq_q[MAG_BITS-1]};
	assign trial = {1'b0, rsh} - {1'b0, dd_q};

	logic sbe, sx, sy, sum_s;
	logic [MAG_BITS-1:0] sum_m;
	always_comb begin
		sbe = (func_q == FUNC_SUB) ? (!sb_q && mbn_q != '0) : sb_q;
		sx = sa_q;
		sy = sbe;
		if (sx == sy) begin
			sum_s = sx; sum_m = p1_q + p2_q;
		end else if (p1_q >= p2_q) begin
			sum_s = sx; sum_m = p1_q - p2_q;
		end else begin
			sum_s = sy; sum_m = p2_q - p1_q;
		end
		if (sum_m == '0) sum_s = 1'b0;
	end

	logic cmp_less, cmp_greater, csa, csb;
	always_comb begin
		csa = sa_q && p1_q != '0;
		csb = sb_q && p2_q != '0;
		cmp_less = 1'b0; cmp_greater = 1'b0;
		if (csa != csb) begin
			cmp_less = csa; cmp_greater = csb;
		end else if (p1_q != p2_q) begin
			if (!csa) begin
				cmp_less = p1_q < p2_q; cmp_greater = p1_q > p2_q;
			end else begin
				cmp_less = p1_q > p2_q; cmp_greater = p1_q < p2_q;
			end
		end
	end

	localparam logic [MAG_BITS-1:0] LIM_POS = (MAG_BITS'(1) << (WORD_BITS - 1)) - 1;
	localparam logic [MAG_BITS-1:0] LIM_NEG = MAG_BITS'(1) << (WORD_BITS - 1);

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				func_q <= func;
				man_q <= mag(a_num); mad_q <= mag(a_den);
				mbn_q <= mag(b_num); mbd_q <= mag(b_den);
				sa_q <= (a_num[WORD_BITS-1] != a_den[WORD_BITS-1]) && a_num != '0;
				sb_q <= (b_num[WORD_BITS-1] != b_den[WORD_BITS-1]) && b_num != '0;
				zero_q <= a_den == '0 || b_den == '0 || (func == FUNC_DIV && b_num == '0);
			end
			OP_MUL_AD_BD: begin den_q <= prod; gx_q <= MAG_BITS'(mad_q); gy_q <= MAG_BITS'(mbd_q); end
			OP_MUL_AN_BD: p1_q <= prod;
			OP_MUL_BN_AD: p2_q <= prod;
			OP_MUL_AN_BN: num_q <= prod;
			// sum over the product of the denominators
			OP_ADD: begin num_q <= sum_m; sr_q <= sum_s; end
			OP_SET_MUL: begin
				sr_q <= (sa_q != sb_q) && num_q != '0;
				gx_q <= num_q; gy_q <= den_q;
			end
			OP_SET_DIV: begin
				num_q <= p1_q; den_q <= p2_q;
				sr_q <= (sa_q != sb_q) && p1_q != '0;
				gx_q <= p1_q; gy_q <= p2_q;
			end
			OP_GCD_START: begin
				if (cmd.sel) begin gx_q <= num_q; gy_q <= den_q; end
			end
			OP_GCD_STEP: begin
				// gy==0 leaves gx as the gcd; otherwise begin remainder division
				if (gy_q != '0) begin
					dq_q <= gx_q; dr_q <= '0; dd_q <= gy_q; dcnt_q <= CW'(MAG_BITS);
					dsel_q <= 1'b1;
				end
			end
			OP_DIV_START: begin
				dsel_q <= 1'b0;
				dr_q <= '0; dcnt_q <= CW'(MAG_BITS);
				if (cmd.sel) begin
					dq_q <= num_q; dd_q <= (gx_q == '0) ? MAG_BITS'(1) : gx_q;
				end else begin
					dq_q <= den_q; dd_q <= (gx_q == '0) ? MAG_BITS'(1) : gx_q;
				end
			end
			OP_DIV_STEP: begin
				if (dcnt_q != '0) begin
					dcnt_q <= dcnt_q - 1'b1;
					if (!trial[MAG_BITS]) begin
						dr_q <= trial[MAG_BITS-1:0];
						dq_q <= {dq_q[MAG_BITS-2:0], 1'b1};
					end else begin
						dr_q <= rsh;
						dq_q <= {dq_q[MAG_BITS-2:0], 1'b0};
					end
				end else if (dsel_q) begin
					gx_q <= gy_q; gy_q <= dr_q; dsel_q <= 1'b0;
				end else if (cmd.sel) begin
					num_q <= dq_q;
				end else begin
					den_q <= dq_q;
				end
			end
			OP_FINISH: begin
				res_num <= '0; res_den <= '0; less <= 1'b0; greater <= 1'b0;
				if (zero_q) begin
					status <= ST_ZERO;
				end else if (func_q > FUNC_DIV) begin
					status <= ST_OK; res_den <= (WORD_BITS-1)'(1);
					less <= cmp_less; greater <= cmp_greater;
				end else if (den_q > LIM_POS || num_q > (sr_q ? LIM_NEG : LIM_POS)) begin
					status <= ST_OVF;
				end else begin
					status <= ST_OK;
					res_num <= sr_q ? (~num_q[WORD_BITS-1:0] + 1'b1) : num_q[WORD_BITS-1:0];
					res_den <= den_q[WORD_BITS-2:0];
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.gcd_done = gy_q == '0;
		stat.div_done = dcnt_q == '0;
		stat.zero_err = zero_q;
		stat.is_cmp = func_q > FUNC_DIV;
		stat.is_addsub = func_q <= FUNC_SUB;
		stat.is_mul = func_q == FUNC_MUL;
	end
endmodule
`default_nettype wire

FILE: hdl/rau_ctrl.sv
// controller: sequences loads, products, gcd loops and divisions, owns the handshakes
// depends on rau_pkg
`timescale 1ns / 1ps
`default_nettype none
module rau_ctrl import rau_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input wire logic out_stall,
	input wire stat_t stat,
	output cmd_t cmd
);
	typedef enum logic [4:0] {
		S_IDLE, S_LOAD, S_PRE, S_P1, S_P2, S_P3, S_P4, S_ADD,
		S_SETR, S_RG, S_RGD, S_RN, S_RND, S_RD, S_RDD, S_FIN, S_OUT
	} state_t;

	state_t state_q;
	logic out_valid_q;

	assign in_stall = state_q != S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.op = OP_NONE; cmd.sel = 1'b0;
		unique case (state_q)
			S_IDLE: if (in_valid) cmd.op = OP_LOAD;
			S_P1: cmd.op = OP_MUL_AD_BD;
			S_P2: cmd.op = OP_MUL_AN_BD;
			S_P3: cmd.op = OP_MUL_BN_AD;
			S_P4: cmd.op = OP_MUL_AN_BN;
			S_RG: cmd.op = stat.gcd_done ? OP_NONE : OP_GCD_STEP;
			S_RGD: cmd.op = OP_DIV_STEP;
			S_ADD: cmd.op = OP_ADD;
			S_SETR: begin
				if (stat.is_addsub) begin
					cmd.op = OP_GCD_START; cmd.sel = 1'b1;
				end else if (stat.is_mul) begin
					cmd.op = OP_SET_MUL;
				end else begin
					cmd.op = OP_SET_DIV;
				end
			end
			S_RN: begin cmd.op = OP_DIV_START; cmd.sel = 1'b1; end
			S_RND: begin cmd.op = OP_DIV_STEP; cmd.sel = 1'b1; end
			S_RD: begin cmd.op = OP_DIV_START; cmd.sel = 1'b0; end
			S_RDD: begin cmd.op = OP_DIV_STEP; cmd.sel = 1'b0; end
			S_FIN: cmd.op = OP_FINISH;
			default: ;
		endcase
	end

	// add and subtract work over the product of the denominators, the gcd reduction
	// then brings the fraction to lowest terms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_LOAD;
				S_LOAD: state_q <= S_PRE;
				S_PRE: state_q <= stat.zero_err ? S_FIN : S_P1;
				S_P1: state_q <= S_P2;
				S_P2: state_q <= S_P3;
				S_P3: state_q <= S_P4;
				S_P4: begin
					if (stat.is_cmp) state_q <= S_FIN;
					else if (stat.is_addsub) state_q <= S_ADD;
					else state_q <= S_SETR;
				end
				S_ADD: state_q <= S_SETR;
				S_SETR: state_q <= S_RG;
				S_RG: if (stat.gcd_done) state_q <= S_RN; else state_q <= S_RGD;
				S_RGD: if (stat.div_done) state_q <= S_RG;
				S_RN: state_q <= S_RND;
				S_RND: if (stat.div_done) state_q <= S_RD;
				S_RD: state_q <= S_RDD;
				S_RDD: if (stat.div_done) state_q <= S_FIN;
				S_FIN: begin state_q <= S_OUT; out_valid_q <= 1'b1; end
				S_OUT: if (!out_stall) begin state_q <= S_IDLE; out_valid_q <= 1'b0; end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: hdl/rational_arithmetic_unit_core.sv
// rational arithmetic unit: exact add, subtract, multiply, divide and compare of fractions
// channels use valid/stall; one transfer out per transfer in; sequencing in rau_ctrl,
// arithmetic in rau_datapath; a single 32x32 multiplier and a radix-2 divider are shared
// depends on rau_pkg, rau_ctrl, rau_datapath
//
// one item at a time: in_stall is high from the cycle after a transfer in until the
// result has been taken. compare skips the gcd and the divisions by the gcd.
// arithmetic runs euclid on 64-bit values with a one-bit-per-cycle divider, one full
// division per remainder step, then two divisions by the gcd, so the time an item
// takes depends on the operands. the result waits in the output register while
// out_stall is high. reset clears the controller; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none
module rational_arithmetic_unit_core import rau_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [2:0] func,
	input wire logic signed [WORD_BITS-1:0] a_num,
	input wire logic signed [WORD_BITS-1:0] a_den,
	input wire logic signed [WORD_BITS-1:0] b_num,
	input wire logic signed [WORD_BITS-1:0] b_den,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [WORD_BITS-1:0] res_num,
	output logic [WORD_BITS-2:0] res_den,
	output logic less,
	output logic greater,
	output logic [1:0] status
);
	cmd_t cmd;
	stat_t stat;
	logic [WORD_BITS-1:0] rn;

	rau_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
	);

	rau_datapath u_dp (
		.clk(clk), .cmd(cmd), .func(func), .a_num(a_num), .a_den(a_den),
		.b_num(b_num), .b_den(b_den), .stat(stat), .res_num(rn), .res_den(res_den),
		.less(less), .greater(greater), .status(status)
	);

	assign res_num = rn;
endmodule
`default_nettype wire

FILE: hdl/rau_checker.sv
// port-level checker for the rational arithmetic unit, bound to the top level
// depends on rau_pkg and rational_arithmetic_unit_core_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "rational_arithmetic_unit_core_assert.svh"
module rau_checker import rau_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [WORD_BITS-1:0] res_num,
	input wire logic [WORD_BITS-2:0] res_den,
	input wire logic less,
	input wire logic greater,
	input wire logic [1:0] status
);
	`RAU_ASSERT(a_one_item, out_valid, in_stall)
	`RAU_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall)
	`RAU_ASSERT(a_flags, out_valid, !(less && greater))
	`RAU_ASSERT(a_err_clear, out_valid && status != ST_OK, res_num == '0 && res_den == '0)
	`RAU_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(res_num))
endmodule

bind rational_arithmetic_unit_core rau_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .res_num(res_num),
	.res_den(res_den), .less(less), .greater(greater), .status(status)
);
`default_nettype wire

FILE: sim/testbench.sv
// self-checking testbench for rational_arithmetic_unit_core: directed table, then random fractions
// expected results come from an exact fraction predictor in this file; depends on rau_pkg
`timescale 1ns / 1ps
module testbench;
	import rau_pkg::*;

	localparam logic [2:0] FUNC_CMP = 3'd4;
	localparam int RANDOM_ITEMS = 650;
	localparam longint CYCLE_LIMIT = 40000000;

	typedef struct packed {
		logic [2:0] func;
		logic [31:0] a_num;
		logic [31:0] a_den;
		logic [31:0] b_num;
		logic [31:0] b_den;
	} frac_op_t;

	typedef struct packed {
		logic [31:0] num;
		logic [30:0] den;
		logic lt;
		logic gt;
		logic [1:0] st;
	} frac_res_t;

	typedef struct packed {
		frac_op_t op;
		logic typed;
		frac_res_t res;
	} row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [2:0] func;
	logic signed [31:0] a_num, a_den, b_num, b_den;
	logic out_valid;
	logic out_stall;
	logic signed [31:0] res_num;
	logic [30:0] res_den;
	logic less, greater;
	logic [1:0] status;

	frac_res_t pending_q[$];
	int errors;
	longint cycles;

	rational_arithmetic_unit_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.out_valid(out_valid), .out_stall(out_stall),
		.res_num(res_num), .res_den(res_den), .less(less), .greater(greater),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] mag_of(logic [31:0] v);
		return v[31] ? (64'h1_0000_0000 - {32'b0, v}) : {32'b0, v};
	endfunction

	function automatic logic [63:0] euclid(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic frac_res_t reduce_frac(frac_op_t op);
		frac_res_t r;
		logic [63:0] man, mad, mbn, mbd, x, y, l, num, den, g;
		logic sa, sb, sbe, sr;
		r = '0;
		man = mag_of(op.a_num);
		mad = mag_of(op.a_den);
		mbn = mag_of(op.b_num);
		mbd = mag_of(op.b_den);
		if (mad == 0 || mbd == 0 || (op.func == FUNC_DIV && mbn == 0)) begin
			r.st = ST_ZERO;
			return r;
		end
		sa = (op.a_num[31] != op.a_den[31]) && man != 0;
		sb = (op.b_num[31] != op.b_den[31]) && mbn != 0;
		if (op.func >= FUNC_CMP) begin
			x = man * mbd;
			y = mbn * mad;
			if (x == 0) sa = 1'b0;
			if (y == 0) sb = 1'b0;
			r.den = 31'd1;
			if (sa != sb) begin
				r.lt = sa;
				r.gt = sb;
			end else if (x != y) begin
				r.lt = sa ? (x > y) : (x < y);
				r.gt = !r.lt;
			end
			return r;
		end
		if (op.func == FUNC_ADD || op.func == FUNC_SUB) begin
			l = (mad / euclid(mad, mbd)) * mbd;
			sbe = (op.func == FUNC_SUB) ? (!sb && mbn != 0) : sb;
			x = man * (l / mad);
			y = mbn * (l / mbd);
			if (sa == sbe) begin
				sr = sa;
				num = x + y;
			end else if (x >= y) begin
				sr = sa;
				num = x - y;
			end else begin
				sr = sbe;
				num = y - x;
			end
			if (num == 0) sr = 1'b0;
			den = l;
		end else begin
			num = (op.func == FUNC_MUL) ? man * mbn : man * mbd;
			den = (op.func == FUNC_MUL) ? mad * mbd : mad * mbn;
			sr = (sa != sb) && num != 0;
		end
		g = euclid(num, den);
		if (g == 0) g = 1;
		num = num / g;
		den = den / g;
		if (den > 64'h7FFF_FFFF || num > (sr ? 64'h8000_0000 : 64'h7FFF_FFFF)) begin
			r.st = ST_OVF;
			return r;
		end
		r.num = sr ? (32'd0 - num[31:0]) : num[31:0];
		r.den = den[30:0];
		return r;
	endfunction

	function automatic logic [31:0] rand_word();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55) return 32'($signed($urandom_range(0, 80)) - 40);
		if (k < 80) return 32'($signed($urandom_range(0, 65535)) - 32768);
		if (k < 85) return {1'b1, 31'd0} + 32'($urandom_range(0, 3));
		if (k < 90) return 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
		return $urandom();
	endfunction

	// sender: bursts of transfers with random gaps
	int burst_left;

	task automatic send(frac_op_t op, logic typed, frac_res_t res);
		in_valid <= 1'b1;
		func <= op.func;
		a_num <= op.a_num;
		a_den <= op.a_den;
		b_num <= op.b_num;
		b_den <= op.b_den;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_q.push_back(typed ? res : reduce_frac(op));
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end else begin
			burst_left--;
		end
	endtask

	row_t dir_rows[$];

	function automatic row_t mk(logic [2:0] f, int an, int ad, int bn, int bd, logic typed,
			int rn, int rd, logic lt, logic gt, logic [1:0] st);
		row_t r;
		r.op = '{f, an, ad, bn, bd};
		r.typed = typed;
		r.res = '{rn, rd[30:0], lt, gt, st};
		return r;
	endfunction

	initial begin
		frac_op_t op;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = '0;
		a_num = '0;
		a_den = '0;
		b_num = '0;
		b_den = '0;
		errors = 0;
		burst_left = 0;
		dir_rows = '{
			mk(FUNC_ADD, 1, 2, 1, 3, 1'b1, 5, 6, 0, 0, ST_OK),
			mk(FUNC_SUB, 1, 2, 1, 3, 1'b1, 1, 6, 0, 0, ST_OK),
			mk(FUNC_MUL, 2, 3, -3, 4, 1'b1, -1, 2, 0, 0, ST_OK),
			mk(FUNC_DIV, 2, 3, 4, -9, 1'b1, -3, 2, 0, 0, ST_OK),
			mk(FUNC_ADD, 1, 0, 1, 1, 1'b1, 0, 0, 0, 0, ST_ZERO),
			mk(FUNC_CMP, 1, 1, 1, 0, 1'b1, 0, 0, 0, 0, ST_ZERO),
			mk(FUNC_DIV, 5, 7, 0, 3, 1'b1, 0, 0, 0, 0, ST_ZERO),
			mk(FUNC_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1, 1'b1, 0, 0, 0, 0, ST_OVF),
			mk(FUNC_SUB, 32'h8000_0000, 1, 1, 1, 1'b1, 0, 0, 0, 0, ST_OVF),
			mk(FUNC_ADD, 32'h8000_0000, 1, 0, 1, 1'b1, 32'h8000_0000, 1, 0, 0, ST_OK),
			mk(FUNC_ADD, 0, 5, 0, -7, 1'b1, 0, 1, 0, 0, ST_OK),
			mk(FUNC_ADD, 3, -4, 0, 1, 1'b1, -3, 4, 0, 0, ST_OK),
			mk(FUNC_MUL, 32'h7FFF_FFFF, 1, 1, 32'h7FFF_FFFF, 1'b1, 1, 1, 0, 0, ST_OK),
			mk(FUNC_CMP, 1, 2, 1, 3, 1'b1, 0, 1, 0, 1, ST_OK),
			mk(FUNC_CMP, -1, 2, 1, -2, 1'b1, 0, 1, 0, 0, ST_OK),
			mk(3'd5, -1, 3, 0, 1, 1'b1, 0, 1, 1, 0, ST_OK),
			mk(3'd6, 0, -3, 0, 7, 1'b1, 0, 1, 0, 0, ST_OK),
			mk(3'd7, 32'h7FFF_FFFF, 1, 32'h8000_0000, 1, 1'b1, 0, 1, 0, 1, ST_OK),
			mk(FUNC_DIV, 1, 32'h7FFF_FFFF, 1, 32'h8000_0000, 1'b0, 0, 0, 0, 0, ST_OK),
			mk(FUNC_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 1, 32'h7FFF_FFFF, 1'b0, 0, 0, 0, 0, ST_OK),
			mk(FUNC_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0,
				0, 0, 0, 0, ST_OK),
			mk(FUNC_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 1, 1, 1'b0, 0, 0, 0, 0, ST_OK)
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) send(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].res);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			op.func = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			op.a_num = rand_word();
			op.a_den = rand_word();
			op.b_num = rand_word();
			op.b_den = rand_word();
			send(op, 1'b0, '0);
		end
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

	// receiver: stall mode is redrawn when its random hold count runs out
	int stall_mode, stall_left;

	initial begin
		out_stall = 1'b0;
		stall_mode = 0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_left = $urandom_range(64, 2000);
			end else begin
				stall_left--;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= $urandom_range(0, 1);
				default: out_stall <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		frac_res_t want, got;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			got = '{res_num, res_den, less, greater, status};
			if (pending_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected transfer out: %p", got);
			end else begin
				want = pending_q.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected num %0d den %0d lt %b gt %b st %0d, got num %0d den %0d lt %b gt %b st %0d",
							$signed(want.num), want.den, want.lt, want.gt, want.st,
							$signed(got.num), got.den, got.lt, got.gt, got.st);
				end
			end
		end
	end

	initial cycles = 0;
endmodule
